### rtl/rsse_pkg.sv
package rsse_pkg;

	localparam int MAX_PARITY  = 32;
	localparam int SYMBOL_BITS = 8;
	localparam int CFG_W       = 6;
	localparam int CNT_W       = $clog2(MAX_PARITY + 2);
	localparam int IDX_W       = $clog2(MAX_PARITY);

	// Field polynomial x^8 + x^4 + x^3 + x^2 + 1.
	localparam logic [SYMBOL_BITS:0] FIELD_POLY = 9'h11D;
	localparam logic [SYMBOL_BITS-1:0] ALPHA = 8'h02;
	localparam logic [CFG_W-1:0] RESET_PARITY = 6'd32;

	typedef logic [SYMBOL_BITS-1:0] sym_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef sym_t [MAX_PARITY-1:0] sym_vec_t;

	typedef struct packed {
		sym_t message_symbol;
		logic final_symbol;
	} in_word_t;

	typedef struct packed {
		sym_t parity_symbol;
		logic parity_last;
	} out_word_t;

	// Generator status seen by the encoder datapath.
	typedef struct packed {
		logic ready;
		cnt_t count;
	} gen_stat_t;

	// GF(256) product: carry-less multiply, then fold the high bits back.
	function automatic sym_t gf_mul(sym_t a, sym_t b);
		logic [2*SYMBOL_BITS-2:0] p;
		p = '0;
		for (int i = 0; i < SYMBOL_BITS; i++) begin
			if (b[i]) begin
				p = p ^ ((2*SYMBOL_BITS-1)'(a) << i);
			end
		end
		for (int k = 2*SYMBOL_BITS-2; k >= SYMBOL_BITS; k--) begin
			if (p[k]) begin
				p = p ^ ((2*SYMBOL_BITS-1)'(FIELD_POLY) << (k - SYMBOL_BITS));
			end
		end
		return p[SYMBOL_BITS-1:0];
	endfunction

	// A count of zero acts as one, anything above the maximum as the maximum.
	function automatic cnt_t clamp_count(logic [CFG_W-1:0] v);
		cnt_t r;
		if (v == '0) begin
			r = cnt_t'(1);
		end else if (int'(v) > MAX_PARITY) begin
			r = cnt_t'(MAX_PARITY);
		end else begin
			r = cnt_t'(v);
		end
		return r;
	endfunction

endpackage

### rtl/rsse_gen.sv
module rsse_gen (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [rsse_pkg::CFG_W-1:0]   cfg_data,
	output rsse_pkg::gen_stat_t          stat,
	output rsse_pkg::sym_vec_t           coef
);
	import rsse_pkg::*;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_STEP,
		ST_READY
	} gen_state_t;

	gen_state_t state_q;
	cnt_t       count_q;
	cnt_t       step_q;
	sym_t       root_q;
	sym_t       g_q [MAX_PARITY+1];

	// One factor (x + root) is multiplied in per cycle, all taps in parallel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			count_q <= clamp_count(RESET_PARITY);
			step_q  <= '0;
		end else if (cfg_write) begin
			state_q <= ST_INIT;
			count_q <= clamp_count(cfg_data);
		end else begin
			unique case (state_q)
				ST_INIT: begin
					state_q <= ST_STEP;
					step_q  <= cnt_t'(2);
				end
				ST_STEP: begin
					if (step_q > count_q) begin
						state_q <= ST_READY;
					end else begin
						step_q <= step_q + cnt_t'(1);
					end
				end
				ST_READY: begin
					state_q <= ST_READY;
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_INIT) begin
			g_q[0] <= ALPHA;
			g_q[1] <= sym_t'(1);
			for (int j = 2; j <= MAX_PARITY; j++) begin
				g_q[j] <= '0;
			end
			root_q <= gf_mul(ALPHA, ALPHA);
		end else if (state_q == ST_STEP && step_q <= count_q) begin
			g_q[0] <= gf_mul(g_q[0], root_q);
			for (int j = 1; j <= MAX_PARITY; j++) begin
				g_q[j] <= g_q[j-1] ^ gf_mul(g_q[j], root_q);
			end
			root_q <= gf_mul(root_q, ALPHA);
		end
	end

	always_comb begin
		stat.ready = (state_q == ST_READY);
		stat.count = count_q;
		for (int j = 0; j < MAX_PARITY; j++) begin
			coef[j] = g_q[j];
		end
	end

endmodule

### rtl/rsse_lfsr.sv
module rsse_lfsr (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  rsse_pkg::gen_stat_t  stat,
	input  rsse_pkg::sym_vec_t   coef,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rsse_pkg::in_word_t   in_data,
	input  logic                 unload_free,
	output logic                 load,
	output rsse_pkg::sym_vec_t   load_vec
);
	import rsse_pkg::*;

	logic     valid_s1;
	in_word_t word_s1;
	logic     advance;
	sym_t     fb;
	sym_t     par_q [MAX_PARITY];
	logic [IDX_W-1:0] top_idx;

	// A final word waits in the input stage until the unloader can take the parity.
	assign advance  = valid_s1 && (!word_s1.final_symbol || unload_free);
	assign in_ready = stat.ready && (!valid_s1 || advance);
	assign load     = advance && word_s1.final_symbol;
	assign top_idx  = IDX_W'(stat.count - cnt_t'(1));
	assign fb       = word_s1.message_symbol ^ par_q[top_idx];

	always_comb begin
		for (int j = 0; j < MAX_PARITY; j++) begin
			if (j < int'(stat.count)) begin
				load_vec[j] = ((j == 0) ? sym_t'(0) : par_q[(j == 0) ? 0 : j-1])
					^ gf_mul(fb, coef[j]);
			end else begin
				load_vec[j] = par_q[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_PARITY; j++) begin
				par_q[j] <= '0;
			end
		end else if (clear || load) begin
			for (int j = 0; j < MAX_PARITY; j++) begin
				par_q[j] <= '0;
			end
		end else if (advance) begin
			for (int j = 0; j < MAX_PARITY; j++) begin
				par_q[j] <= load_vec[j];
			end
		end
	end

endmodule

### rtl/rsse_unload.sv
module rsse_unload (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rsse_pkg::cnt_t       count,
	input  logic                 load,
	input  rsse_pkg::sym_vec_t   load_vec,
	output logic                 unload_free,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rsse_pkg::out_word_t  out_data
);
	import rsse_pkg::*;

	cnt_t rem_q;
	sym_t hold_q [MAX_PARITY];
	logic pop;
	logic [IDX_W-1:0] top_idx;

	assign pop         = out_valid && out_ready;
	assign unload_free = (rem_q == '0) || (rem_q == cnt_t'(1) && out_ready);
	assign out_valid   = (rem_q != '0);
	assign top_idx     = IDX_W'(count - cnt_t'(1));

	assign out_data.parity_symbol = hold_q[top_idx];
	assign out_data.parity_last   = (rem_q == cnt_t'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= count;
		end else if (pop) begin
			rem_q <= rem_q - cnt_t'(1);
		end
	end

	// Shift toward the top tap so the next symbol is always at count - 1.
	always_ff @(posedge clk) begin
		if (load) begin
			for (int j = 0; j < MAX_PARITY; j++) begin
				hold_q[j] <= load_vec[j];
			end
		end else if (pop) begin
			hold_q[0] <= '0;
			for (int j = 1; j < MAX_PARITY; j++) begin
				hold_q[j] <= hold_q[j-1];
			end
		end
	end

endmodule

### rtl/reed_solomon_systematic_encoder_core.sv
// Channel  Direction  Handshake              Word
// in       input      in_valid / in_ready    in_data   (message_symbol, final_symbol)
// out      output     out_valid / out_ready  out_data  (parity_symbol, parity_last)
// cfg      input      cfg_write              cfg_data  (parity_count, 6 bits)
//
// A message word can be taken every cycle while in_ready is high; it is held in the
// input stage and the parity register is updated as it leaves. After a final word
// the parity words go out one per cycle while out_ready is high. After reset, and
// after each parity_count write, in_ready stays low while the generator is
// rebuilt. A final word stalls in the input stage only while the previous block's
// parity words are still being unloaded.
module reed_solomon_systematic_encoder_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  rsse_pkg::in_word_t           in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output rsse_pkg::out_word_t          out_data,
	input  logic                         cfg_write,
	input  logic [rsse_pkg::CFG_W-1:0]   cfg_data
);
	import rsse_pkg::*;

	gen_stat_t stat;
	sym_vec_t  coef;
	sym_vec_t  load_vec;
	logic      load;
	logic      unload_free;

	// Generator polynomial coefficients, rebuilt one root per cycle.
	rsse_gen u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.coef      (coef)
	);

	// Input stage and parity shift register; all taps update together.
	rsse_lfsr u_lfsr (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (cfg_write),
		.stat        (stat),
		.coef        (coef),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.unload_free (unload_free),
		.load        (load),
		.load_vec    (load_vec)
	);

	// Parity hold register that emits the block highest degree first.
	rsse_unload u_unload (
		.clk         (clk),
		.arst_n      (arst_n),
		.count       (stat.count),
		.load        (load),
		.load_vec    (load_vec),
		.unload_free (unload_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule
